// ----- rtl/gfs_pkg.sv -----
package gfs_pkg;

    localparam int ADDR_W       = 5;
    localparam int SCALE_DENOM  = 10;
    localparam int ROW_PIX_MAX  = 40;

    localparam logic [5:0] SCALE_MIN  = 6'd5;
    localparam logic [5:0] SCALE_MAX  = 6'd50;
    localparam logic [3:0] WIDTH_MAX  = 4'd8;
    localparam logic [5:0] HEIGHT_MAX = 6'd32;

    // floor(x / 10) as (x * 52429) >> 19, exact for x below 43690
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [2:0] REG_SCALE    = 3'd0;
    localparam logic [2:0] REG_FWIDTH   = 3'd1;
    localparam logic [2:0] REG_FHEIGHT  = 3'd2;
    localparam logic [2:0] REG_SCR_W    = 3'd3;
    localparam logic [2:0] REG_SCR_H    = 3'd4;
    localparam logic [2:0] REG_BACK     = 3'd5;

    // shared multiplier step codes
    localparam logic [3:0] STEP_SW   = 4'd0;
    localparam logic [3:0] STEP_SH   = 4'd1;
    localparam logic [3:0] STEP_SY   = 4'd2;
    localparam logic [3:0] STEP_LIM  = 4'd3;
    localparam logic [3:0] STEP_COL0 = 4'd4;
    localparam logic [3:0] STEP_COL7 = 4'd11;
    localparam logic [3:0] STEP_LAST = 4'd12;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_MASK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [5:0]  scale;
        logic [3:0]  fwidth;
        logic [5:0]  fheight;
        logic [15:0] scr_w;
        logic [15:0] scr_h;
        logic [31:0] back;
    } cfg_t;

    function automatic logic [8:0] div10(input logic [11:0] x);
        logic [27:0] p;
        p = x * DIV10_RECIP;
        return p[27:DIV10_SHIFT];
    endfunction

    function automatic logic [ROW_PIX_MAX-1:0] lowmask(input logic [5:0] k);
        logic [ROW_PIX_MAX-1:0] ones;
        ones = '1;
        return ~(ones << k);
    endfunction

endpackage

// ----- rtl/glyph_row_fractional_scaler_top.sv -----
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | glyph_bits, origin_x, origin_y, fore_color_in
// out     | output    | out_valid / out_stall | pixel_y .. char_done, one transfer per scaled row
// cfg     | input     | apb psel / penable    | six registers at byte address 4*i
//
// no new item is taken while one is in work: in_stall stays high from acceptance until idle,
// through 13 sequencer steps on one shared multiplier (12 products for width, height, start
// row, row limit and column edges), a mask state and an emit state for 0 to 5 scaled rows
// rst_n clears the sequencer, the row counter and out_valid; registers take reset values
// a stall on out holds the output register and the sequencer waits for it
module glyph_row_fractional_scaler_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gfs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 glyph_bits,
    input  logic [15:0]                origin_x,
    input  logic [15:0]                origin_y,
    input  logic [31:0]                fore_color_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [16:0]                pixel_y,
    output logic [15:0]                pixel_x,
    output logic [39:0]                fore_mask,
    output logic [39:0]                visible_mask,
    output logic [5:0]                 row_width,
    output logic [31:0]                fore_color,
    output logic [31:0]                back_color_out,
    output logic                       last_of_run,
    output logic                       char_done
);
    import gfs_pkg::*;

    cfg_t cfg;

    state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [4:0]  srow_reg, srow_next;
    logic        out_valid_reg, out_valid_next;

    logic [7:0]  glyph_reg;
    logic [15:0] ox_reg;
    logic [15:0] oy_reg;
    logic [31:0] fc_reg;
    logic [11:0] prod_reg, prod_next;
    logic [5:0]  sw_reg, sw_next;
    logic [7:0]  sh_reg, sh_next;
    logic [7:0]  sy_reg, sy_next;
    logic [10:0] lim_reg, lim_next;
    logic [5:0]  cstart_reg, cstart_next;
    logic [39:0] fmask_reg, fmask_next;
    logic [39:0] vmask_reg, vmask_next;

    logic [16:0] py_reg;
    logic [39:0] fm_reg;
    logic [39:0] vm_reg;
    logic [31:0] fco_reg;
    logic [31:0] bco_reg;
    logic [5:0]  rw_reg;
    logic [15:0] px_reg;
    logic        last_reg;
    logic        done_reg;

    logic        accept;
    logic        out_free;
    logic [5:0]  mul_a;
    logic [3:0]  mul_add;
    logic [3:0]  wb_step;
    logic [8:0]  quot;
    logic [2:0]  col;
    logic [8:0]  sw_raw;
    logic [15:0] vis_room;
    logic [5:0]  vis_cnt;
    logic [11:0] sy10;
    logic [11:0] sy10_nx;
    logic [7:0]  sy_inc;
    logic        row_ok;
    logic        next_ok;
    logic        load;
    logic [16:0] py_calc;

    gfs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // shared multiplier operand select
    always_comb
    begin
        case (step_reg)
            STEP_SW:
            begin
                mul_a   = {2'd0, cfg.fwidth};
                mul_add = 4'd0;
            end
            STEP_SH:
            begin
                mul_a   = cfg.fheight;
                mul_add = 4'd0;
            end
            STEP_SY:
            begin
                mul_a   = {1'b0, srow_reg};
                mul_add = 4'(SCALE_DENOM - 1);
            end
            STEP_LIM:
            begin
                mul_a   = {1'b0, srow_reg} + 6'd1;
                mul_add = 4'd0;
            end
            default:
            begin
                mul_a   = {2'd0, step_reg - STEP_COL0} + 6'd1;
                mul_add = 4'(SCALE_DENOM - 1);
            end
        endcase
    end

    assign wb_step  = step_reg - 4'd1;
    assign quot     = div10(prod_reg);
    assign col      = 3'(wb_step - STEP_COL0);
    assign sw_raw   = quot;
    assign vis_room = cfg.scr_w - ox_reg;
    assign vis_cnt  = (vis_room < {10'd0, sw_reg}) ? vis_room[5:0] : sw_reg;

    assign sy10    = ({4'd0, sy_reg} << 3) + ({4'd0, sy_reg} << 1);
    assign sy10_nx = sy10 + 12'(SCALE_DENOM);
    assign sy_inc  = sy_reg + 8'd1;
    assign row_ok  = (sy_reg < sh_reg) && (sy10 < {1'b0, lim_reg});
    assign next_ok = (sy_inc < sh_reg) && (sy10_nx < {1'b0, lim_reg});
    assign load    = (state_reg == ST_EMIT) && row_ok && out_free;
    assign py_calc = {1'b0, oy_reg} + {9'd0, sy_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CALC;
            ST_CALC: if (step_reg == STEP_LAST) state_next = ST_MASK;
            ST_MASK: state_next = ST_EMIT;
            ST_EMIT: if (!row_ok) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and counters
    always_comb
    begin
        step_next      = step_reg;
        srow_next      = srow_reg;
        prod_next      = prod_reg;
        sw_next        = sw_reg;
        sh_next        = sh_reg;
        sy_next        = sy_reg;
        lim_next       = lim_reg;
        cstart_next    = cstart_reg;
        fmask_next     = fmask_reg;
        vmask_next     = vmask_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                step_next   = STEP_SW;
                cstart_next = 6'd0;
                fmask_next  = '0;
            end
            ST_CALC:
            begin
                step_next = step_reg + 4'd1;
                prod_next = 12'(mul_a * cfg.scale) + {8'd0, mul_add};
                if (step_reg != STEP_SW)
                begin
                    case (wb_step)
                        STEP_SW:  sw_next = (sw_raw > 9'(ROW_PIX_MAX)) ?
                                            6'(ROW_PIX_MAX) : sw_raw[5:0];
                        STEP_SH:  sh_next = quot[7:0];
                        STEP_SY:  sy_next = quot[7:0];
                        STEP_LIM: lim_next = prod_reg[10:0];
                        default:
                        begin
                            if (wb_step <= STEP_COL7)
                            begin
                                if (glyph_reg[col])
                                begin
                                    fmask_next = fmask_reg | (lowmask(quot[5:0]) &
                                                 ~lowmask(cstart_reg));
                                end
                                cstart_next = quot[5:0];
                            end
                        end
                    endcase
                end
            end
            ST_MASK:
            begin
                fmask_next = fmask_reg & lowmask(sw_reg);
                vmask_next = (ox_reg >= cfg.scr_w) ? '0 : lowmask(vis_cnt);
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    sy_next        = sy_inc;
                    out_valid_next = 1'b1;
                end
                if (!row_ok)
                begin
                    srow_next = (({1'b0, srow_reg} + 6'd1) >= cfg.fheight) ?
                                5'd0 : srow_reg + 5'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_SW;
            srow_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            srow_reg      <= srow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            glyph_reg <= glyph_bits;
            ox_reg    <= origin_x;
            oy_reg    <= origin_y;
            fc_reg    <= fore_color_in;
        end
        prod_reg   <= prod_next;
        sw_reg     <= sw_next;
        sh_reg     <= sh_next;
        sy_reg     <= sy_next;
        lim_reg    <= lim_next;
        cstart_reg <= cstart_next;
        fmask_reg  <= fmask_next;
        vmask_reg  <= vmask_next;
        if (load)
        begin
            py_reg   <= py_calc;
            px_reg   <= ox_reg;
            fm_reg   <= fmask_reg;
            vm_reg   <= (py_calc < {1'b0, cfg.scr_h}) ? vmask_reg : '0;
            rw_reg   <= sw_reg;
            fco_reg  <= fc_reg;
            bco_reg  <= cfg.back;
            last_reg <= !next_ok;
            done_reg <= (sy_inc == sh_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign pixel_y        = py_reg;
    assign pixel_x        = px_reg;
    assign fore_mask      = fm_reg;
    assign visible_mask   = vm_reg;
    assign row_width      = rw_reg;
    assign fore_color     = fco_reg;
    assign back_color_out = bco_reg;
    assign last_of_run    = last_reg;
    assign char_done      = done_reg;

endmodule

// ----- rtl/gfs_cfg.sv -----
module gfs_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gfs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output gfs_pkg::cfg_t              cfg
);
    import gfs_pkg::*;

    logic [5:0]  scale_reg;
    logic [3:0]  fwidth_reg;
    logic [5:0]  fheight_reg;
    logic [15:0] scr_w_reg;
    logic [15:0] scr_h_reg;
    logic [31:0] back_reg;
    logic        wr_en;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= 6'd10;
            fwidth_reg  <= 4'd8;
            fheight_reg <= 6'd16;
            scr_w_reg   <= 16'd1024;
            scr_h_reg   <= 16'd768;
            back_reg    <= 32'd0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SCALE:   scale_reg   <= pwdata[5:0];
                REG_FWIDTH:  fwidth_reg  <= pwdata[3:0];
                REG_FHEIGHT: fheight_reg <= pwdata[5:0];
                REG_SCR_W:   scr_w_reg   <= pwdata[15:0];
                REG_SCR_H:   scr_h_reg   <= pwdata[15:0];
                REG_BACK:    back_reg    <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SCALE:   prdata = {26'd0, scale_reg};
            REG_FWIDTH:  prdata = {28'd0, fwidth_reg};
            REG_FHEIGHT: prdata = {26'd0, fheight_reg};
            REG_SCR_W:   prdata = {16'd0, scr_w_reg};
            REG_SCR_H:   prdata = {16'd0, scr_h_reg};
            REG_BACK:    prdata = back_reg;
            default:     prdata = 32'd0;
        endcase
    end

    // copies for the datapath, with scale, width and height saturated to their ranges
    always_comb
    begin
        cfg.scale   = (scale_reg < SCALE_MIN) ? SCALE_MIN :
                      ((scale_reg > SCALE_MAX) ? SCALE_MAX : scale_reg);
        cfg.fwidth  = (fwidth_reg == 4'd0) ? 4'd1 :
                      ((fwidth_reg > WIDTH_MAX) ? WIDTH_MAX : fwidth_reg);
        cfg.fheight = (fheight_reg == 6'd0) ? 6'd1 :
                      ((fheight_reg > HEIGHT_MAX) ? HEIGHT_MAX : fheight_reg);
        cfg.scr_w   = scr_w_reg;
        cfg.scr_h   = scr_h_reg;
        cfg.back    = back_reg;
    end

endmodule
